FILE: hdl/prid_pkg.sv
`timescale 1ns / 1ps

package prid_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int CFG_W             = 9;   // palette_entries register
    localparam int CNT_W             = 10;  // palette byte counter, up to 3*256
    localparam int RGB_W             = 24;

    typedef enum logic [2:0] {
        PH_PALETTE,
        PH_TYPE,
        PH_LENGTH,
        PH_RUN_INDEX,
        PH_LITERAL
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_TRUNC
    } status_t;

    localparam logic [7:0] RUN_TYPE = 8'd1;

    // Per-byte decision from the parser to the datapath.
    typedef struct packed {
        logic                 emit;     // a result leaves for this byte
        logic                 rd;       // palette read issued for it
        logic                 wr;       // palette entry completed
        logic [RGB_W-1:0]     wr_rgb;
        status_t              status;
        logic [7:0]           count;
    } step_t;

endpackage

FILE: hdl/prid_palette_mem.sv
`timescale 1ns / 1ps

module prid_palette_mem #(
    parameter int DEPTH = prid_pkg::PALETTE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [prid_pkg::RGB_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [prid_pkg::RGB_W-1:0]  rd_data
);
    import prid_pkg::*;

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read, so a stalled result keeps its color
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/prid_ctrl.sv
`timescale 1ns / 1ps

module prid_ctrl #(
    parameter int DEPTH = prid_pkg::PALETTE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_data,
    input  logic [prid_pkg::CFG_W-1:0]  palette_entries,
    output prid_pkg::step_t             step,
    output logic [AW-1:0]               rd_addr,
    output logic [AW-1:0]               wr_addr
);
    import prid_pkg::*;

    localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(DEPTH);

    phase_t            phase_reg,   phase_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [1:0]        sel_reg,     sel_next;
    logic [AW-1:0]     entry_reg,   entry_next;
    logic [7:0]        red_reg,     red_next;
    logic [7:0]        green_reg,   green_next;
    logic              is_run_reg,  is_run_next;
    logic [7:0]        length_reg,  length_next;
    logic [7:0]        remain_reg,  remain_next;

    logic [CFG_W-1:0]  entry_count;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  cnt_inc;
    logic [7:0]        remain_dec;
    logic              out_of_range;
    logic              incomplete;
    phase_t            eff_phase;

    assign entry_count  = (palette_entries > DEPTH_CFG) ? DEPTH_CFG : palette_entries;
    assign total        = CNT_W'({entry_count, 1'b0}) + CNT_W'(entry_count);
    assign cnt_inc      = cnt_reg + CNT_W'(1);
    assign remain_dec   = remain_reg - 8'd1;
    assign out_of_range = {1'b0, data_byte} >= entry_count;
    assign rd_addr      = data_byte[AW-1:0];
    assign wr_addr      = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PALETTE;
            cnt_reg    <= '0;
            sel_reg    <= '0;
            entry_reg  <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
            is_run_reg <= 1'b0;
            length_reg <= '0;
            remain_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
            entry_reg  <= entry_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            is_run_reg <= is_run_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        entry_next  = entry_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        is_run_next = is_run_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        incomplete  = 1'b0;
        step        = '0;
        step.status = ST_OK;
        step.wr_rgb = {red_reg, green_reg, data_byte};

        // a finished (or empty) palette hands this byte to the packet parser
        eff_phase = (phase_reg == PH_PALETTE && cnt_reg >= total) ? PH_TYPE : phase_reg;

        if (accept) begin
            phase_next = eff_phase;
            case (eff_phase)
                PH_PALETTE: begin
                    case (sel_reg)
                        2'd0: begin
                            red_next = data_byte;
                            sel_next = 2'd1;
                        end
                        2'd1: begin
                            green_next = data_byte;
                            sel_next   = 2'd2;
                        end
                        default: begin
                            step.wr    = 1'b1;
                            sel_next   = 2'd0;
                            entry_next = entry_reg + AW'(1);
                        end
                    endcase
                    cnt_next   = cnt_inc;
                    incomplete = cnt_inc < total;
                end
                PH_TYPE: begin
                    is_run_next = (data_byte == RUN_TYPE);
                    phase_next  = PH_LENGTH;
                    incomplete  = 1'b1;
                end
                PH_LENGTH: begin
                    length_next = data_byte;
                    if (is_run_reg) begin
                        phase_next = PH_RUN_INDEX;
                        incomplete = 1'b1;
                    end else if (data_byte == 8'd0) begin
                        phase_next = PH_TYPE;
                    end else begin
                        remain_next = data_byte;
                        phase_next  = PH_LITERAL;
                        incomplete  = 1'b1;
                    end
                end
                PH_RUN_INDEX: begin
                    if (length_reg != 8'd0) begin
                        step.emit   = 1'b1;
                        step.count  = length_reg;
                        step.status = out_of_range ? ST_RANGE : ST_OK;
                        step.rd     = !out_of_range;
                    end
                    phase_next = PH_TYPE;
                end
                PH_LITERAL: begin
                    remain_next = remain_dec;
                    if (remain_dec == 8'd0) begin
                        phase_next = PH_TYPE;
                    end else begin
                        incomplete = 1'b1;
                    end
                    step.emit   = 1'b1;
                    step.count  = 8'd1;
                    step.status = out_of_range ? ST_RANGE : ST_OK;
                    step.rd     = !out_of_range;
                end
                default: begin
                    phase_next = PH_PALETTE;
                    cnt_next   = '0;
                    sel_next   = '0;
                    entry_next = '0;
                end
            endcase

            if (end_of_data) begin
                if (incomplete) begin
                    // truncation report replaces any pixel of this byte
                    step.emit   = 1'b1;
                    step.rd     = 1'b0;
                    step.count  = 8'd0;
                    step.status = ST_TRUNC;
                end
                phase_next = PH_PALETTE;
                cnt_next   = '0;
                sel_next   = '0;
                entry_next = '0;
            end
        end
    end

endmodule

FILE: hdl/palette_rle_image_decoder_top.sv
`timescale 1ns / 1ps

// Palette run-length image decoder.
// Input stream (s_*): one coded byte per transfer in s_tdata, s_tlast set on
// the final byte of an image. The first 3*palette_entries bytes load the RGB
// palette; then come packets of type byte, length byte and index byte(s).
// Output stream (m_*): one transfer per run or literal pixel, with zero color and
// a range status for an index beyond the palette, or a status-only report for a truncated image.
// Config channel (cfg_*): palette_entries, always ready; write it only while
// the decoder is idle.
// Throughput: one byte per cycle while m_* is not stalled. Each byte is one parser
// step plus at most one palette read; the palette RAM read port is used at most once per byte.
// Pipeline: two register stages. The edge that takes a byte also registers its
// palette read and the read stage; the output register is loaded from the read
// stage once it is free, and it drives m_*.
// Reset (aresetn low, synchronous) clears the parser to palette loading and
// the register to zero; palette contents are undefined until loaded.
// When m_tready is low, one result waits in the output register and one in
// the read stage; s_tready drops only once both are occupied.
module palette_rle_image_decoder_top #(
    parameter int PALETTE_DEPTH = prid_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [prid_pkg::CFG_W-1:0]  cfg_data,      // palette_entries
    // coded byte stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,       // [7:0] data_byte
    input  logic                        s_tlast,       // end_of_data
    // pixel results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,       // red, green, blue, pixel_count
    output logic [1:0]                  m_tuser        // [1:0] status
);
    import prid_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [CFG_W-1:0]  entries_reg;
    logic              s_accept;
    step_t             step;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [RGB_W-1:0]  rd_data;

    // read stage: result waiting on the palette read data
    logic              s1_valid_reg;
    logic [7:0]        s1_count_reg;
    status_t           s1_status_reg;

    // output register
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    logic              out_free;
    logic              s1_move;
    logic [RGB_W-1:0]  color;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            entries_reg <= cfg_data;
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    prid_ctrl #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (s_accept),
        .data_byte       (s_tdata),
        .end_of_data     (s_tlast),
        .palette_entries (entries_reg),
        .step            (step),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr)
    );

    prid_palette_mem #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (step.wr),
        .wr_addr (wr_addr),
        .wr_data (step.wr_rgb),
        .rd_en   (step.rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // read stage; step.emit is only set on an accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= step.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && step.emit) begin
            s1_count_reg  <= step.count;
            s1_status_reg <= step.status;
        end
    end

    // colors only on a good pixel
    assign color = (s1_status_reg == ST_OK) ? rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_data_reg <= {s1_count_reg, color[7:0], color[15:8], color[23:16]};
            m_user_reg <= s1_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // a full read stage with a stalled output must hold off the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |-> !s_tready)
        else $error("input taken while read stage blocked");

    // palette reads only for in-range pixels that leave as results
    a_read_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        step.rd |-> step.emit && step.status == ST_OK && s_accept)
        else $error("palette read without a good pixel");

    // loading and pixel lookup never share a byte
    a_wr_rd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step.wr && step.rd))
        else $error("palette write and read on the same byte");

    // a truncation report carries no color and no pixels
    a_trunc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg == ST_TRUNC |-> m_data_reg == '0)
        else $error("truncation report with payload");
`endif

endmodule

FILE: tb/palette_rle_image_decoder_top_tb.sv
`timescale 1ns / 1ps

module palette_rle_image_decoder_top_tb;
    import prid_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 1200;
    localparam int unsigned SETTLE_CYCLES = 6;   // two-stage pipe plus margin

    // One decoded pixel transfer as seen on m_tdata / m_tuser.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] count;
        status_t    status;
    } pixel_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    // Directed step: a coded byte or a register write. When typed is set, the
    // byte's result is the one written here instead of the predicted one.
    typedef struct packed {
        row_kind_t kind;
        logic [8:0] val;
        logic       eod;
        logic       typed;
        pixel_t     want;
    } row_t;

    localparam pixel_t NO_PX = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    // Decoder shadow state.
    logic [8:0]  pal_entries = '0;
    phase_t      ph = PH_PALETTE;
    logic [9:0]  pal_cnt = '0;
    logic [23:0] pal_mem [256];
    logic [7:0]  hold_r = '0;
    logic [7:0]  hold_g = '0;
    logic        is_run = 1'b0;
    logic [7:0]  pkt_len = '0;
    logic [7:0]  lit_left = '0;

    pixel_t      pending_pixels [$];
    int unsigned errors = 0;
    int unsigned pixels_seen = 0;
    int unsigned cycles = 0;
    logic        steady = 1'b0;   // no idling on either side while set

    row_t script [33] = '{
        // empty palette after reset: every index is out of range
        '{ROW_BYTE, 9'h001, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h005, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'd5, ST_RANGE}},
        // zero-length literal packet
        '{ROW_BYTE, 9'h000, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h000, 1'b0, 1'b0, NO_PX},
        // data ends right after a type byte
        '{ROW_BYTE, 9'h0FF, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'd0, ST_TRUNC}},
        '{ROW_CFG,  9'h001, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h0FF, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h000, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h080, 1'b0, 1'b0, NO_PX},
        // longest run
        '{ROW_BYTE, 9'h001, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h0FF, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h000, 1'b0, 1'b1, '{8'hFF, 8'h00, 8'h80, 8'd255, ST_OK}},
        // zero-length run: index taken, never checked
        '{ROW_BYTE, 9'h001, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h000, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h0FF, 1'b0, 1'b0, NO_PX},
        // literal list cut short; the report replaces the last pixel
        '{ROW_BYTE, 9'h0FE, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h004, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h000, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h001, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'd1, ST_RANGE}},
        '{ROW_BYTE, 9'h000, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'd0, ST_TRUNC}},
        // register lowered in the middle of a palette load
        '{ROW_CFG,  9'h003, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h011, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h022, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h033, 1'b0, 1'b0, NO_PX},
        '{ROW_CFG,  9'h001, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h001, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h007, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h000, 1'b1, 1'b0, NO_PX},
        // data ends inside the palette
        '{ROW_CFG,  9'h002, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h044, 1'b0, 1'b0, NO_PX},
        '{ROW_BYTE, 9'h055, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'd0, ST_TRUNC}},
        // above the palette depth: clamps to 256 entries
        '{ROW_CFG,  9'h1FF, 1'b0, 1'b0, NO_PX}
    };

    palette_rle_image_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),   // palette_entries
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] data_byte
        .s_tlast   (s_tlast),    // end_of_data
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] red, [15:8] green, [23:16] blue, [31:24] pixel_count
        .m_tuser   (m_tuser)     // [1:0] status
    );

    always #5 aclk = ~aclk;

    // Entries actually in use: the register saturates at the store depth.
    function automatic int unsigned live_entries();
        return (pal_entries > 9'd256) ? 256 : int'(pal_entries);
    endfunction

    function automatic pixel_t palette_pixel(input logic [7:0] idx, input logic [7:0] cnt);
        pixel_t px;
        if (int'(idx) >= live_entries()) begin
            px = '{8'h00, 8'h00, 8'h00, cnt, ST_RANGE};
        end else begin
            px = '{pal_mem[idx][23:16], pal_mem[idx][15:8], pal_mem[idx][7:0], cnt, ST_OK};
        end
        return px;
    endfunction

    // Advances the shadow decoder by one coded byte.
    function automatic void decode_byte(input logic [7:0] b, input logic eod,
                                        output logic emit, output pixel_t px);
        int unsigned total;
        logic        incomplete;
        total = 3 * live_entries();
        incomplete = 1'b0;
        emit = 1'b0;
        px = NO_PX;
        if (ph == PH_PALETTE && int'(pal_cnt) >= total) ph = PH_TYPE;
        case (ph)
            PH_PALETTE: begin
                case (pal_cnt % 3)
                    0: hold_r = b;
                    1: hold_g = b;
                    default: pal_mem[pal_cnt / 3] = {hold_r, hold_g, b};
                endcase
                pal_cnt = pal_cnt + 10'd1;
                incomplete = int'(pal_cnt) < total;
            end
            PH_TYPE: begin
                is_run = (b == RUN_TYPE);
                ph = PH_LENGTH;
                incomplete = 1'b1;
            end
            PH_LENGTH: begin
                pkt_len = b;
                if (is_run) begin
                    ph = PH_RUN_INDEX;
                    incomplete = 1'b1;
                end else if (b == 8'd0) begin
                    ph = PH_TYPE;
                end else begin
                    lit_left = b;
                    ph = PH_LITERAL;
                    incomplete = 1'b1;
                end
            end
            PH_RUN_INDEX: begin
                if (pkt_len != 8'd0) begin
                    emit = 1'b1;
                    px = palette_pixel(b, pkt_len);
                end
                ph = PH_TYPE;
            end
            PH_LITERAL: begin
                lit_left = lit_left - 8'd1;
                if (lit_left == 8'd0) ph = PH_TYPE;
                else incomplete = 1'b1;
                if (!(eod && incomplete)) begin
                    emit = 1'b1;
                    px = palette_pixel(b, 8'd1);
                end
            end
            default: begin
                ph = PH_PALETTE;
                pal_cnt = '0;
            end
        endcase
        if (eod) begin
            if (incomplete) begin
                emit = 1'b1;
                px = '{8'h00, 8'h00, 8'h00, 8'd0, ST_TRUNC};
            end
            ph = PH_PALETTE;
            pal_cnt = '0;
        end
    endfunction

    // Mostly an entry in range; sometimes an index at or beyond the palette end, always so for an empty palette.
    function automatic logic [7:0] pick_index(input int unsigned n_ent);
        if (n_ent == 0 || (n_ent < 256 && $urandom_range(0, 5) == 0))
            return 8'($urandom_range(n_ent, 255));
        return 8'($urandom_range(0, n_ent - 1));
    endfunction

    task automatic flag(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH pixel %0d %s: got %0d expected %0d", pixels_seen, what, got, want);
    endtask

    // One byte transfer; its expected pixel, if any, is queued on acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eod, input logic typed,
                             input pixel_t want);
        int unsigned gap;
        logic        emit;
        pixel_t      px;
        @(negedge aclk);
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eod;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, eod, emit, px);
        if (typed) pending_pixels.insert(pending_pixels.size(), want);
        else if (emit) pending_pixels.insert(pending_pixels.size(), px);
    endtask

    // Drain the decoder, then write palette_entries.
    task automatic write_cfg(input logic [8:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        pal_entries = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall before each transfer, none while steady is set.
    initial begin
        int unsigned wait_cycles;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            wait_cycles = steady ? 0 : $urandom_range(0, 19);
            if (wait_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each pixel transfer with the oldest expectation.
    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24], m_tuser};
            if (pending_pixels.size() == 0) begin
                flag("unexpected transfer, status", int'(got.status), -1);
            end else begin
                want = pending_pixels.pop_front();
                if (got.red != want.red) flag("red", got.red, want.red);
                if (got.green != want.green) flag("green", got.green, want.green);
                if (got.blue != want.blue) flag("blue", got.blue, want.blue);
                if (got.count != want.count) flag("pixel_count", got.count, want.count);
                if (got.status != want.status)
                    flag("status", int'(got.status), int'(want.status));
            end
            pixels_seen++;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0]  img [$];
        int unsigned sent;
        int unsigned n_ent;
        int unsigned len;
        int unsigned r;
        int unsigned big_left;
        logic [8:0]  v;
        logic [7:0]  t;
        sent = 0;
        big_left = 2;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG)
                write_cfg(script[i].val);
            else
                send_byte(script[i].val[7:0], script[i].eod, script[i].typed, script[i].want);
        end

        // Random images: mostly a full palette and well-formed packets, some
        // cut short at a random byte, some plain noise.
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) < 3) begin
                r = $urandom_range(0, 19);
                if (r == 0) v = 9'd0;
                else if (r < 12) v = 9'($urandom_range(1, 8));
                else if (r < 17) v = 9'($urandom_range(9, 80));
                else if (big_left != 0) begin
                    big_left--;
                    v = (r == 17) ? 9'd255 : (r == 18) ? 9'd256 : 9'($urandom_range(257, 511));
                end else v = 9'($urandom_range(1, 8));
                write_cfg(v);
            end
            steady = ($urandom_range(0, 4) == 0);
            n_ent = live_entries();
            img.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 24)) img.insert(img.size(), 8'($urandom));
            end else begin
                repeat (3 * n_ent) img.insert(img.size(), 8'($urandom));
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1) == 1) begin
                        img.insert(img.size(), RUN_TYPE);
                        r = $urandom_range(0, 9);
                        img.insert(img.size(), (r == 0) ? 8'd0 : (r == 1) ? 8'd255
                                               : 8'($urandom_range(1, 254)));
                        img.insert(img.size(), pick_index(n_ent));
                    end else begin
                        t = 8'($urandom);
                        if (t == RUN_TYPE) t = 8'd0;
                        img.insert(img.size(), t);
                        r = $urandom_range(0, 19);
                        len = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 60)
                                                      : $urandom_range(1, 6);
                        img.insert(img.size(), 8'(len));
                        repeat (len) img.insert(img.size(), pick_index(n_ent));
                    end
                end
                // truncated image: end of data at an arbitrary byte
                if ($urandom_range(0, 5) == 0 && img.size() > 1) begin
                    len = $urandom_range(1, img.size() - 1);
                    while (img.size() > len) void'(img.pop_back());
                end
            end
            foreach (img[i]) send_byte(img[i], i == img.size() - 1, 1'b0, NO_PX);
            sent += img.size();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: palette_rle_image_decoder_top.f
hdl/prid_pkg.sv
hdl/prid_palette_mem.sv
hdl/prid_ctrl.sv
hdl/palette_rle_image_decoder_top.sv
tb/palette_rle_image_decoder_top_tb.sv
